@@ src/pfc_pkg.sv @@
package pfc_pkg;

	localparam int IDX_W = 6;
	localparam int CNT_W = 6;
	localparam int COUNT_W = 7;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_ADD,
		OP_KSTEP,
		OP_TMUL1,
		OP_TMUL2,
		OP_TACC,
		OP_MAG,
		OP_NSTEP,
		OP_SQ,
		OP_SQRT,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_STORE,
		OP_RD,
		OP_FAIL,
		OP_EMIT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_FIT,
		S_KSRCH,
		S_TMUL1,
		S_TMUL2,
		S_TACC,
		S_MAG,
		S_NORM,
		S_SQ,
		S_SQRT,
		S_DIVI,
		S_DIVR,
		S_RES,
		S_DRAIN
	} ctl_state_t;

	typedef struct packed {
		dp_op_t           op;
		logic [1:0]       sel;
		logic [2:0]       term;
		logic [IDX_W-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic               last;
		logic               few;
		logic               in_range;
		logic               singular;
		logic               norm_done;
		logic               div_done;
		logic [COUNT_W-1:0] count;
	} dp_status_t;

	// Column taken from each row by the six terms of a 3x3 determinant.
	function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] row);
		logic [5:0] cols;
		cols = 6'b100100;
		case (t)
			3'd0: cols = 6'b100100;
			3'd1: cols = 6'b001001;
			3'd2: cols = 6'b010010;
			3'd3: cols = 6'b000110;
			3'd4: cols = 6'b100001;
			3'd5: cols = 6'b011000;
			default: cols = 6'b100100;
		endcase
		case (row)
			2'd0: return cols[1:0];
			2'd1: return cols[3:2];
			default: return cols[5:4];
		endcase
	endfunction

	function automatic logic term_neg(input logic [2:0] t);
		return t >= 3'd3;
	endfunction

	// Index into the six distinct entries of the symmetric moment matrix.
	function automatic logic [2:0] sym_idx(input logic [1:0] r, input logic [1:0] c);
		case ({r, c})
			4'b0000: return 3'd0;
			4'b0001, 4'b0100: return 3'd1;
			4'b0010, 4'b1000: return 3'd2;
			4'b0101: return 3'd3;
			4'b0110, 4'b1001: return 3'd4;
			4'b1010: return 3'd5;
			default: return 3'd0;
		endcase
	endfunction

endpackage

@@ src/pfc_ram.sv @@
module pfc_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/pfc_datapath.sv @@
module pfc_datapath #(
	parameter int MAX_POINTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pfc_pkg::dp_cmd_t    cmd,
	output pfc_pkg::dp_status_t stat,
	input  logic                cfg_write,
	input  logic [19:0]         cfg_data,
	input  logic signed [19:0]  px,
	input  logic signed [19:0]  py,
	input  logic signed [19:0]  pz,
	input  logic                last_point,
	output logic signed [15:0]  normal_x,
	output logic signed [15:0]  normal_y,
	output logic signed [15:0]  normal_z,
	output logic [19:0]         plane_offset,
	output logic                flat,
	output logic                status
);
	import pfc_pkg::*;

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int SW  = 40 + AW;
	localparam int FW  = 21 + AW;
	localparam logic signed [SW-1:0] SLIM = SW'(1 << 20);
	localparam logic signed [FW-1:0] FLIM = FW'(1 << 20);

	logic [19:0]             flat_limit_q;
	logic [CW-1:0]           count_q;
	logic signed [SW-1:0]    m_q [6];
	logic signed [FW-1:0]    f_q [3];
	logic [4:0]              k_q;
	logic                    last_q, store_q;
	logic signed [19:0]      pt_x_q, pt_y_q, pt_z_q;
	logic signed [39:0]      prod_q [6];
	logic signed [41:0]      p1_q;
	logic signed [62:0]      p2_q;
	logic signed [63:0]      det_q [4];
	logic [63:0]             mg_q [3];
	logic signed [6:0]       e_q;
	logic [61:0]             sq_s1;
	logic [63:0]             q_q;
	logic [32:0]             rem_q;
	logic [31:0]             root_q;
	logic [63:0]             dvd_q;
	logic [31:0]             drem_q;
	logic [21:0]             quo_q;
	logic                    ovf_q;
	logic [6:0]              dcnt_q;
	logic signed [15:0]      res_n_q [3];
	logic [19:0]             res_off_q;
	logic                    res_flat_q, res_stat_q;
	logic                    rd_v_s1, v_s2;
	logic signed [35:0]      rp_s2 [3];
	logic signed [15:0]      o_nx_q, o_ny_q, o_nz_q;
	logic [19:0]             o_off_q;
	logic                    o_flat_q, o_stat_q;

	logic                    ram_we;
	logic [59:0]             ram_rdata;
	logic signed [19:0]      rx, ry, rz;
	logic                    rng, big, narrow;
	logic signed [20:0]      m_e [6];
	logic signed [20:0]      s_e [3];
	logic signed [20:0]      op_e [3];
	logic [1:0]              col;
	logic [63:0]             mg_sel;
	logic [46:0]             dn;
	logic signed [8:0]       n_off;
	logic [32:0]             dremx;
	logic [34:0]             sremx, strial;
	logic [15:0]             dc;
	logic                    dneg;
	logic signed [63:0]      tbase;
	logic signed [38:0]      racc, rlim;

	assign ram_we = (cmd.op == OP_LOAD) && (count_q < CW'(MAX_POINTS));

	pfc_ram #(.WIDTH(60), .DEPTH(MAX_POINTS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({px, py, pz}),
		.raddr (cmd.idx[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign rx = ram_rdata[59:40];
	assign ry = ram_rdata[39:20];
	assign rz = ram_rdata[19:0];

	always_comb begin
		rng = 1'b1;
		for (int i = 0; i < 6; i++) begin
			if (!(m_q[i] < SLIM && m_q[i] > -SLIM)) rng = 1'b0;
			m_e[i] = m_q[i][20:0];
		end
		for (int i = 0; i < 3; i++) begin
			if (!(f_q[i] < FLIM && f_q[i] > -FLIM)) rng = 1'b0;
			s_e[i] = 21'(-f_q[i]);
		end
	end

	// Operands of one determinant term; column sel-1 carries the right-hand side.
	always_comb begin
		col = 2'd0;
		for (int r = 0; r < 3; r++) begin
			col = perm_col(cmd.term, 2'(r));
			if (cmd.sel != 2'd0 && col == cmd.sel - 2'd1) begin
				op_e[r] = s_e[r];
			end else begin
				op_e[r] = m_e[sym_idx(2'(r), col)];
			end
		end
	end

	always_comb begin
		big    = |(mg_q[0][63:31] | mg_q[1][63:31] | mg_q[2][63:31]);
		narrow = ~|(mg_q[0][63:30] | mg_q[1][63:30] | mg_q[2][63:30]);
		unique case (cmd.sel)
			2'd0: mg_sel = mg_q[0];
			2'd1: mg_sel = mg_q[1];
			default: mg_sel = mg_q[2];
		endcase
		dn     = 47'({mg_sel[30:0], 15'b0}) + 47'(root_q[31:1]);
		n_off  = 9'sd65 + $signed({4'b0, k_q}) - 9'(e_q);
		dremx  = {drem_q, dvd_q[63]};
		sremx  = {rem_q, q_q[63:62]};
		strial = {1'b0, root_q, 2'b01};
		dc     = (ovf_q || quo_q > 22'd32768) ? 16'd32768 : quo_q[15:0];
		unique case (cmd.sel)
			2'd0: dneg = det_q[1][63] ^ det_q[0][63];
			2'd1: dneg = det_q[2][63] ^ det_q[0][63];
			default: dneg = det_q[3][63] ^ det_q[0][63];
		endcase
		if (!dneg && dc > 16'd32767) dc = 16'd32767;
		tbase = (cmd.term == 3'd0) ? 64'sd0 : det_q[cmd.sel];
		racc  = 39'(rp_s2[0]) + 39'(rp_s2[1]) + 39'(rp_s2[2])
			+ $signed({4'b0, res_off_q, 15'b0});
		rlim  = $signed({4'b0, flat_limit_q, 15'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_limit_q <= 20'd102;
			count_q      <= '0;
			k_q          <= '0;
			last_q       <= 1'b0;
			store_q      <= 1'b0;
			dcnt_q       <= '0;
			rd_v_s1      <= 1'b0;
			v_s2         <= 1'b0;
			for (int i = 0; i < 6; i++) m_q[i] <= '0;
			for (int i = 0; i < 3; i++) f_q[i] <= '0;
		end else begin
			if (cfg_write) flat_limit_q <= cfg_data;
			rd_v_s1 <= (cmd.op == OP_RD);
			v_s2    <= rd_v_s1;
			unique case (cmd.op)
				OP_LOAD: begin
					last_q  <= last_point;
					store_q <= count_q < CW'(MAX_POINTS);
				end
				OP_ADD: begin
					if (store_q) begin
						for (int i = 0; i < 6; i++) m_q[i] <= m_q[i] + SW'(prod_q[i]);
						f_q[0]  <= f_q[0] + FW'(pt_x_q);
						f_q[1]  <= f_q[1] + FW'(pt_y_q);
						f_q[2]  <= f_q[2] + FW'(pt_z_q);
						count_q <= count_q + CW'(1);
					end
				end
				OP_KSTEP: begin
					if (!rng) begin
						for (int i = 0; i < 6; i++) m_q[i] <= m_q[i] >>> 2;
						for (int i = 0; i < 3; i++) f_q[i] <= f_q[i] >>> 1;
						k_q <= k_q + 5'd1;
					end
				end
				OP_DIV_INIT: dcnt_q <= (cmd.sel == 2'd3) ? 7'(n_off) : 7'd47;
				OP_DIV_STEP: dcnt_q <= dcnt_q - 7'd1;
				OP_EMIT, OP_FAIL: begin
					if (cmd.op == OP_EMIT) begin
						for (int i = 0; i < 6; i++) m_q[i] <= '0;
						for (int i = 0; i < 3; i++) f_q[i] <= '0;
						count_q <= '0;
						k_q     <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			rp_s2[0] <= 36'(res_n_q[0]) * 36'(rx);
			rp_s2[1] <= 36'(res_n_q[1]) * 36'(ry);
			rp_s2[2] <= 36'(res_n_q[2]) * 36'(rz);
		end
		if (v_s2 && (racc > rlim || racc < -rlim)) res_flat_q <= 1'b0;
		unique case (cmd.op)
			OP_LOAD: begin
				pt_x_q <= px;
				pt_y_q <= py;
				pt_z_q <= pz;
			end
			OP_MUL: begin
				prod_q[0] <= 40'(pt_x_q) * 40'(pt_x_q);
				prod_q[1] <= 40'(pt_x_q) * 40'(pt_y_q);
				prod_q[2] <= 40'(pt_x_q) * 40'(pt_z_q);
				prod_q[3] <= 40'(pt_y_q) * 40'(pt_y_q);
				prod_q[4] <= 40'(pt_y_q) * 40'(pt_z_q);
				prod_q[5] <= 40'(pt_z_q) * 40'(pt_z_q);
			end
			OP_TMUL1: p1_q <= 42'(op_e[0]) * 42'(op_e[1]);
			OP_TMUL2: p2_q <= 63'(p1_q) * 63'(op_e[2]);
			OP_TACC: begin
				det_q[cmd.sel] <= term_neg(cmd.term) ? tbase - 64'(p2_q)
					: tbase + 64'(p2_q);
			end
			OP_MAG: begin
				for (int i = 0; i < 3; i++) begin
					mg_q[i] <= det_q[i+1][63] ? 64'(-det_q[i+1]) : 64'(det_q[i+1]);
				end
				e_q <= '0;
			end
			OP_NSTEP: begin
				if (big) begin
					for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] >> 1;
					e_q <= e_q + 7'sd1;
				end else if (narrow) begin
					for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] << 1;
					e_q <= e_q - 7'sd1;
				end
			end
			OP_SQ: begin
				if (cmd.idx[1:0] != 2'd3) sq_s1 <= mg_sel[30:0] * mg_sel[30:0];
				if (cmd.idx[1:0] == 2'd0) begin
					q_q    <= '0;
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					q_q <= q_q + 64'(sq_s1);
				end
			end
			OP_SQRT: begin
				q_q <= q_q << 2;
				if (sremx >= strial) begin
					rem_q  <= 33'(sremx - strial);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= sremx[32:0];
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			OP_DIV_INIT: begin
				dvd_q  <= (cmd.sel == 2'd3) ? (det_q[0][63] ? 64'(-det_q[0]) : 64'(det_q[0]))
					: {dn, 17'b0};
				drem_q <= '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
			end
			OP_DIV_STEP: begin
				dvd_q <= dvd_q << 1;
				ovf_q <= ovf_q | quo_q[21];
				if (dremx >= {1'b0, root_q}) begin
					drem_q <= 32'(dremx - {1'b0, root_q});
					quo_q  <= {quo_q[20:0], 1'b1};
				end else begin
					drem_q <= dremx[31:0];
					quo_q  <= {quo_q[20:0], 1'b0};
				end
			end
			OP_DIV_STORE: begin
				if (cmd.sel == 2'd3) begin
					res_off_q  <= (ovf_q || quo_q >= 22'h1FFFFF) ? 20'hFFFFF
						: 20'((quo_q + 22'd1) >> 1);
					res_flat_q <= 1'b1;
					res_stat_q <= 1'b0;
				end else begin
					res_n_q[cmd.sel] <= dneg ? -$signed(dc) : $signed(dc);
				end
			end
			OP_FAIL: begin
				for (int i = 0; i < 3; i++) res_n_q[i] <= '0;
				res_off_q  <= '0;
				res_flat_q <= 1'b0;
				res_stat_q <= 1'b1;
			end
			OP_EMIT: begin
				o_nx_q   <= res_n_q[0];
				o_ny_q   <= res_n_q[1];
				o_nz_q   <= res_n_q[2];
				o_off_q  <= res_off_q;
				o_flat_q <= res_flat_q;
				o_stat_q <= res_stat_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.last      = last_q;
	assign stat.few       = count_q < CW'(3);
	assign stat.in_range  = rng;
	assign stat.singular  = (det_q[0] == 64'sd0)
		|| (det_q[1] == 64'sd0 && det_q[2] == 64'sd0 && det_q[3] == 64'sd0);
	assign stat.norm_done = !big && !narrow;
	assign stat.div_done  = (dcnt_q == 7'd0);
	assign stat.count     = COUNT_W'(count_q);

	assign normal_x     = o_nx_q;
	assign normal_y     = o_ny_q;
	assign normal_z     = o_nz_q;
	assign plane_offset = o_off_q;
	assign flat         = o_flat_q;
	assign status       = o_stat_q;

endmodule

@@ src/pfc_ctrl.sv @@
module pfc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output pfc_pkg::dp_cmd_t    cmd,
	input  pfc_pkg::dp_status_t stat
);
	import pfc_pkg::*;

	ctl_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       sel_q, sel_d;
	logic [2:0]       term_q, term_d;
	logic             out_valid_q;
	logic             emit_ok;
	logic             res_last;

	// A waiting result blocks only the hand-over of the next one.
	assign emit_ok  = !out_valid_q || !out_stall;
	assign res_last = (COUNT_W'(cnt_q) + COUNT_W'(1)) == stat.count;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		sel_d   = sel_q;
		term_d  = term_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_MUL;
			S_MUL: state_d = S_ADD;
			S_ADD: state_d = stat.last ? S_FIT : S_IDLE;
			S_FIT: state_d = stat.few ? S_DRAIN : S_KSRCH;
			S_KSRCH: begin
				if (stat.in_range) begin
					state_d = S_TMUL1;
					sel_d   = 2'd0;
					term_d  = 3'd0;
				end
			end
			S_TMUL1: state_d = S_TMUL2;
			S_TMUL2: state_d = S_TACC;
			S_TACC: begin
				state_d = S_TMUL1;
				if (term_q == 3'd5) begin
					term_d = 3'd0;
					if (sel_q == 2'd3) state_d = S_MAG;
					else sel_d = sel_q + 2'd1;
				end else begin
					term_d = term_q + 3'd1;
				end
			end
			S_MAG: state_d = stat.singular ? S_DRAIN : S_NORM;
			S_NORM: begin
				if (stat.norm_done) begin
					state_d = S_SQ;
					cnt_d   = '0;
				end
			end
			S_SQ: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(3)) begin
					state_d = S_SQRT;
					cnt_d   = '0;
				end
			end
			S_SQRT: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(31)) begin
					state_d = S_DIVI;
					sel_d   = 2'd0;
				end
			end
			S_DIVI: state_d = S_DIVR;
			S_DIVR: begin
				if (stat.div_done) begin
					if (sel_q == 2'd3) begin
						state_d = S_RES;
						cnt_d   = '0;
					end else begin
						state_d = S_DIVI;
						sel_d   = sel_q + 2'd1;
					end
				end
			end
			S_RES: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (res_last) begin
					state_d = S_DRAIN;
					cnt_d   = '0;
				end
			end
			// The drain state first lets the residual pipeline settle, then the
			// result is handed over once the output register is free.
			S_DRAIN: begin
				if (cnt_q != CNT_W'(2)) cnt_d = cnt_q + CNT_W'(1);
				else if (emit_ok) begin
					state_d = S_IDLE;
					cnt_d   = '0;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.sel  = sel_q;
		cmd.term = term_q;
		cmd.idx  = IDX_W'(cnt_q);
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_MUL: cmd.op = OP_MUL;
			S_ADD: cmd.op = OP_ADD;
			S_FIT: if (stat.few) cmd.op = OP_FAIL;
			S_KSRCH: if (!stat.in_range) cmd.op = OP_KSTEP;
			S_TMUL1: cmd.op = OP_TMUL1;
			S_TMUL2: cmd.op = OP_TMUL2;
			S_TACC: cmd.op = OP_TACC;
			S_MAG: cmd.op = stat.singular ? OP_FAIL : OP_MAG;
			S_NORM: if (!stat.norm_done) cmd.op = OP_NSTEP;
			// The step count selects the normal component squared in each step; the last step only adds the final square.
			S_SQ: begin
				cmd.op  = OP_SQ;
				cmd.sel = cnt_q[1:0];
			end
			S_SQRT: cmd.op = OP_SQRT;
			S_DIVI: cmd.op = OP_DIV_INIT;
			S_DIVR: cmd.op = stat.div_done ? OP_DIV_STORE : OP_DIV_STEP;
			S_RES: cmd.op = OP_RD;
			S_DRAIN: if (cnt_q == CNT_W'(2) && emit_ok) cmd.op = OP_EMIT;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sel_q       <= '0;
			term_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
			term_q  <= term_d;
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/plane_fit_and_check.sv @@
// Channel   Handshake            Payload
// in        in_valid / in_stall  px, py, pz, last_point
// out       out_valid/ out_stall normal_x, normal_y, normal_z, plane_offset, flat, status
// cfg       cfg_write            cfg_data (flat_limit)
//
// A point beat runs through accept, moment products and accumulation, in that order.
// The fit after the last point is paced by the shared determinant multipliers, the
// one-bit normalising shifter, the 32-step square root and the bit-serial divider.
// Reset is asynchronous and clears the sums, the point count and flat_limit to 102.
// A stalled result holds in the output register; the next set's points are still taken.
module plane_fit_and_check #(
	parameter int MAX_POINTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [19:0] px,
	input  logic signed [19:0] py,
	input  logic signed [19:0] pz,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [19:0]        plane_offset,
	output logic               flat,
	output logic               status,
	input  logic               cfg_write,
	input  logic [19:0]        cfg_data
);
	import pfc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t stat;

	pfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	pfc_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.px           (px),
		.py           (py),
		.pz           (pz),
		.last_point   (last_point),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.plane_offset (plane_offset),
		.flat         (flat),
		.status       (status)
	);

endmodule
